[design/spp_pkg.sv]
// Shared types and constants for the strong probable prime test block.
// Used by spp_modmul, spp_seq and strong_probable_prime_test; no dependencies.

package spp_pkg;

    // Default datapath width in bits
    localparam int SPP_NUM_WIDTH = 32;

    // Width of the candidate and base fields on the stream
    localparam int SPP_FIELD_WIDTH = 32;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_POW,
        ST_MULX_WAIT,
        ST_SQR_GO,
        ST_SQR_WAIT,
        ST_CHECK,
        ST_LOOP,
        ST_LOOP_WAIT,
        ST_FINISH
    } spp_state_t;

    // Verdict of one test
    typedef struct packed {
        logic invalid_candidate;
        logic probable_prime;
    } spp_result_t;

    // Sequencer status seen by the stream wrapper
    typedef struct packed {
        logic idle;
        logic done;
    } spp_status_t;

endpackage

[design/spp_modmul.sv]
// Interleaved radix-2 modular multiplier, one multiplier bit per cycle.
// Depends on spp_pkg for the default width.

module spp_modmul #(
    parameter int NUM_WIDTH = spp_pkg::SPP_NUM_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mul_start,
    input  logic [NUM_WIDTH-1:0] op_x,     // multiplicand, below op_m
    input  logic [NUM_WIDTH-1:0] op_y,     // multiplier, any value
    input  logic [NUM_WIDTH-1:0] op_m,     // modulus, at least 2
    output logic                 mul_done,
    output logic [NUM_WIDTH-1:0] mul_result
);

    localparam int CNT_W = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] acc_reg, x_reg, y_reg, m_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg, done_reg;

    logic [NUM_WIDTH+1:0] sum, m1, m2, sub1, sub2;
    logic [NUM_WIDTH-1:0] acc_next;

    // 2*acc + bit*x stays below 3m; fold it back with two parallel compares
    always_comb begin
        sum  = {1'b0, acc_reg, 1'b0} + {2'b00, (y_reg[NUM_WIDTH-1] ? x_reg : '0)};
        m1   = {2'b00, m_reg};
        m2   = {1'b0, m_reg, 1'b0};
        sub1 = sum - m1;
        sub2 = sum - m2;
        if (sum >= m2) begin
            acc_next = sub2[NUM_WIDTH-1:0];
        end else if (sum >= m1) begin
            acc_next = sub1[NUM_WIDTH-1:0];
        end else begin
            acc_next = sum[NUM_WIDTH-1:0];
        end
    end

    // Control: busy while the bit count runs down, then a one-cycle done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (mul_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_WIDTH - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    // Operands and accumulator
    always_ff @(posedge aclk) begin
        if (mul_start) begin
            acc_reg <= '0;
            x_reg   <= op_x;
            y_reg   <= op_y;
            m_reg   <= op_m;
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            y_reg   <= {y_reg[NUM_WIDTH-2:0], 1'b0};
        end
    end

    assign mul_done   = done_reg;
    assign mul_result = acc_reg;

`ifndef ASSERT_OFF
    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !busy_reg && !done_reg)
        else $error("modmul started while busy");

    a_result_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> acc_reg < m_reg)
        else $error("modmul result not reduced");

    a_busy_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg != '0 |=> busy_reg && !done_reg)
        else $error("modmul stopped early");
`endif

endmodule

[design/spp_seq.sv]
// Sequencer for one Miller-Rabin round: split of n-1, a^d mod n, squarings.
// Depends on spp_pkg and drives the shared spp_modmul unit.

module spp_seq #(
    parameter int NUM_WIDTH = spp_pkg::SPP_NUM_WIDTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [NUM_WIDTH-1:0]  n_in,
    input  logic [NUM_WIDTH-1:0]  a_in,
    input  logic                  out_free,
    output spp_pkg::spp_status_t  status,
    output spp_pkg::spp_result_t  result
);

    localparam int CNT_W = $clog2(NUM_WIDTH);

    spp_pkg::spp_state_t  state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic [NUM_WIDTH-1:0] x_reg, x_next;
    logic [NUM_WIDTH-1:0] sq_reg, sq_next;
    logic [CNT_W-1:0]     s_reg, s_next;
    spp_pkg::spp_result_t res_reg, res_next;

    logic                 mul_start, mul_done;
    logic [NUM_WIDTH-1:0] op_x, op_y, mul_result, n_m1;

    assign n_m1 = n_reg - NUM_WIDTH'(1);

    // Shared modular multiplier
    spp_modmul #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_modmul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mul_start  (mul_start),
        .op_x       (op_x),
        .op_y       (op_y),
        .op_m       (n_reg),
        .mul_done   (mul_done),
        .mul_result (mul_result)
    );

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= spp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        n_reg   <= n_next;
        d_reg   <= d_next;
        x_reg   <= x_next;
        sq_reg  <= sq_next;
        s_reg   <= s_next;
        res_reg <= res_next;
    end

    // Next state and outputs
    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        sq_next    = sq_reg;
        s_next     = s_reg;
        res_next   = res_reg;
        mul_start  = 1'b0;
        op_x       = x_reg;
        op_y       = sq_reg;
        status     = '0;
        case (state_reg)
            spp_pkg::ST_IDLE: begin
                status.idle = 1'b1;
                if (start) begin
                    n_next  = n_in;
                    d_next  = n_in - NUM_WIDTH'(1);
                    sq_next = a_in;
                    s_next  = '0;
                    if (n_in < NUM_WIDTH'(2)) begin
                        res_next   = '{invalid_candidate: 1'b1, probable_prime: 1'b0};
                        state_next = spp_pkg::ST_FINISH;
                    end else begin
                        res_next   = '0;
                        state_next = spp_pkg::ST_SPLIT;
                    end
                end
            end
            // strip trailing zeros of n-1
            spp_pkg::ST_SPLIT: begin
                if (d_reg[0]) begin
                    state_next = spp_pkg::ST_RED_GO;
                end else begin
                    d_next = {1'b0, d_reg[NUM_WIDTH-1:1]};
                    s_next = s_reg + CNT_W'(1);
                end
            end
            // a mod n as 1 * a mod n
            spp_pkg::ST_RED_GO: begin
                mul_start  = 1'b1;
                op_x       = NUM_WIDTH'(1);
                op_y       = sq_reg;
                state_next = spp_pkg::ST_RED_WAIT;
            end
            spp_pkg::ST_RED_WAIT: begin
                if (mul_done) begin
                    sq_next    = mul_result;
                    x_next     = NUM_WIDTH'(1);
                    state_next = spp_pkg::ST_POW;
                end
            end
            // square-and-multiply, low bit of d first
            spp_pkg::ST_POW: begin
                if (d_reg == '0) begin
                    state_next = spp_pkg::ST_CHECK;
                end else if (d_reg[0]) begin
                    mul_start  = 1'b1;
                    op_x       = x_reg;
                    op_y       = sq_reg;
                    state_next = spp_pkg::ST_MULX_WAIT;
                end else begin
                    state_next = spp_pkg::ST_SQR_GO;
                end
            end
            spp_pkg::ST_MULX_WAIT: begin
                if (mul_done) begin
                    x_next     = mul_result;
                    state_next = spp_pkg::ST_SQR_GO;
                end
            end
            spp_pkg::ST_SQR_GO: begin
                mul_start  = 1'b1;
                op_x       = sq_reg;
                op_y       = sq_reg;
                state_next = spp_pkg::ST_SQR_WAIT;
            end
            spp_pkg::ST_SQR_WAIT: begin
                if (mul_done) begin
                    sq_next    = mul_result;
                    d_next     = {1'b0, d_reg[NUM_WIDTH-1:1]};
                    state_next = spp_pkg::ST_POW;
                end
            end
            spp_pkg::ST_CHECK: begin
                if (x_reg == NUM_WIDTH'(1)) begin
                    res_next.probable_prime = 1'b1;
                    state_next              = spp_pkg::ST_FINISH;
                end else begin
                    state_next = spp_pkg::ST_LOOP;
                end
            end
            // up to s squarings, each value checked against n-1 first
            spp_pkg::ST_LOOP: begin
                if (s_reg == '0) begin
                    state_next = spp_pkg::ST_FINISH;
                end else if (x_reg == n_m1) begin
                    res_next.probable_prime = 1'b1;
                    state_next              = spp_pkg::ST_FINISH;
                end else begin
                    mul_start  = 1'b1;
                    op_x       = x_reg;
                    op_y       = x_reg;
                    s_next     = s_reg - CNT_W'(1);
                    state_next = spp_pkg::ST_LOOP_WAIT;
                end
            end
            spp_pkg::ST_LOOP_WAIT: begin
                if (mul_done) begin
                    x_next     = mul_result;
                    state_next = spp_pkg::ST_LOOP;
                end
            end
            // hand the verdict over once the output register is free
            spp_pkg::ST_FINISH: begin
                if (out_free) begin
                    status.done = 1'b1;
                    state_next  = spp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spp_pkg::ST_IDLE;
            end
        endcase
    end

    assign result = res_reg;

`ifndef ASSERT_OFF
    a_done_while_waiting: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_done |-> state_reg == spp_pkg::ST_RED_WAIT || state_reg == spp_pkg::ST_MULX_WAIT
                  || state_reg == spp_pkg::ST_SQR_WAIT || state_reg == spp_pkg::ST_LOOP_WAIT)
        else $error("multiplier result arrived outside a wait state");

    a_invalid_not_prime: assert property (@(posedge aclk) disable iff (!aresetn)
        status.done && result.invalid_candidate |-> !result.probable_prime)
        else $error("invalid candidate reported prime");

    a_split_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == spp_pkg::ST_SPLIT |-> d_reg != '0)
        else $error("split of n-1 started on zero");
`endif

endmodule

[design/strong_probable_prime_test.sv]
// Top level of the strong probable prime test: stream ports and output register.
// Depends on spp_pkg and spp_seq (which holds spp_modmul).

// One Miller-Rabin round per input transfer: the candidate n and base a come in
// on the slave side, and one verdict goes out on the master side. s_tready is
// high only while the sequencer is idle; a finished verdict waits in the output
// register, so a new transfer is taken while the previous verdict is still
// pending. A test runs one reduction of a, one squaring per bit of d plus one
// multiplication per set bit of d, and up to s final squarings, where s is the
// number of trailing zeros of n-1 and d is n-1 with those zeros stripped. Each
// multiplication runs through the single radix-2 multiplier at one bit per
// cycle. The finished verdict may also wait for the output register to be free.
// A candidate below two skips the round and goes straight to its verdict.

module strong_probable_prime_test #(
    parameter int NUM_WIDTH = spp_pkg::SPP_NUM_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] candidate, [63:32] witness_base
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] probable_prime, [1] invalid_candidate, rest 0
);

    localparam int FW = spp_pkg::SPP_FIELD_WIDTH;

    logic [2*FW-1:0]      cand_ext, base_ext;
    logic [NUM_WIDTH-1:0] n_in, a_in;
    logic                 start, out_free;
    spp_pkg::spp_status_t status;
    spp_pkg::spp_result_t result;
    logic                 m_tvalid_reg;
    spp_pkg::spp_result_t out_reg;

    // Fields cut or zero-extended to the datapath width
    assign cand_ext = {{FW{1'b0}}, s_tdata[FW-1:0]};
    assign base_ext = {{FW{1'b0}}, s_tdata[2*FW-1:FW]};
    assign n_in     = cand_ext[NUM_WIDTH-1:0];
    assign a_in     = base_ext[NUM_WIDTH-1:0];

    assign s_tready = status.idle;
    assign start    = s_tvalid && status.idle;
    assign out_free = !m_tvalid_reg || m_tready;

    spp_seq #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .n_in     (n_in),
        .a_in     (a_in),
        .out_free (out_free),
        .status   (status),
        .result   (result)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (status.done) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (status.done) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, out_reg.invalid_candidate, out_reg.probable_prime};

endmodule

[dv/tb.sv]
// Self-checking testbench for strong_probable_prime_test: one Miller-Rabin round per transfer.
// Depends on spp_pkg and the design sources; verdicts come from a predictor built into this file.

module tb;

    localparam int NUM_WIDTH = spp_pkg::SPP_NUM_WIDTH;
    localparam longint unsigned WIDTH_MASK =
        (NUM_WIDTH >= 64) ? ~64'd0 : ((64'd1 << NUM_WIDTH) - 64'd1);
    // Cycles without any transfer before the run is declared hung
    localparam int QUIET_LIMIT = 40000;
    localparam int TAIL_CYCLES = 50;

    typedef struct {
        logic [31:0]          cand;
        logic [31:0]          base;
        spp_pkg::spp_result_t verdict;
    } pending_verdict_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] candidate, [63:32] witness_base
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [0] probable_prime, [1] invalid_candidate, rest 0

    pending_verdict_t expected_verdicts[$];
    int  err_count    = 0;
    int  quiet_cycles = 0;
    bit  tx_idle_on   = 1'b0;
    bit  rx_idle_on   = 1'b0;
    int  rx_stall_left = 0;

    strong_probable_prime_test #(
        .NUM_WIDTH(NUM_WIDTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock, period 10
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // Operands stay below 2^32, so the product fits in 64 bits
    function automatic longint unsigned mul_mod_n(input longint unsigned x, y, m);
        return (x * y) % m;
    endfunction

    function automatic longint unsigned pow_mod_n(input longint unsigned b, e, m);
        longint unsigned r;
        longint unsigned sq;
        longint unsigned k;
        r  = 1;
        sq = b % m;
        k  = e;
        while (k != 0) begin
            if (k[0]) r = mul_mod_n(r, sq, m);
            sq = mul_mod_n(sq, sq, m);
            k  = k >> 1;
        end
        return r;
    endfunction

    // One round for n >= 2: split n-1 = d * 2^s, then walk the squaring chain
    function automatic bit strong_round(input longint unsigned n, a);
        longint unsigned d;
        longint unsigned x;
        int s;
        d = n - 1;
        s = 0;
        while (!d[0]) begin
            d = d >> 1;
            s++;
        end
        x = pow_mod_n(a, d, n);
        if (x == 1) return 1'b1;
        for (int r = 0; r < s; r++) begin
            if (x == n - 1) return 1'b1;
            x = mul_mod_n(x, x, n);
        end
        return 1'b0;
    endfunction

    function automatic spp_pkg::spp_result_t predict_verdict(input logic [31:0] cand, base);
        longint unsigned n;
        longint unsigned a;
        spp_pkg::spp_result_t v;
        n = 64'(cand) & WIDTH_MASK;
        a = 64'(base) & WIDTH_MASK;
        v = '0;
        if (n < 2) v.invalid_candidate = 1'b1;
        else       v.probable_prime    = strong_round(n, a);
        return v;
    endfunction

    // Bases 2, 7 and 61 decide primality for every 32-bit value
    function automatic bit is_prime32(input logic [31:0] cand);
        longint unsigned n;
        n = 64'(cand);
        if (n < 2) return 1'b0;
        if (n == 2 || n == 7 || n == 61) return 1'b1;
        return strong_round(n, 2) && strong_round(n, 7) && strong_round(n, 61);
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // Half full width, the rest spread over smaller sizes
    function automatic logic [31:0] random_candidate();
        int w;
        logic [31:0] v;
        w = ($urandom_range(0, 1) == 0) ? 32 : $urandom_range(2, 31);
        v = $urandom;
        if (w < 32) v = v & ((32'd1 << w) - 32'd1);
        v[w-1] = 1'b1;
        return v;
    endfunction

    function automatic logic [31:0] random_prime();
        logic [31:0] n;
        do begin
            n    = random_candidate();
            n[0] = 1'b1;
        end while (!is_prime32(n));
        return n;
    endfunction

    function automatic logic [31:0] random_base(input logic [31:0] cand);
        int r;
        longint unsigned k;
        r = $urandom_range(0, 99);
        if (r < 8)  return 32'd0;
        if (r < 16) return 32'hFFFF_FFFF;
        if (r < 24 && cand >= 2) begin
            k = $urandom_range(0, 32'hFFFF_FFFF / cand);
            return 32'(k * 64'(cand));
        end
        if (r < 30) return cand - 32'd1;
        return $urandom;
    endfunction

    // Mostly back-to-back, sometimes short, rarely long enough to land mid-test
    function automatic int pick_gap();
        int r;
        if (!tx_idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(20, 3500);
    endfunction

    // Send one test; returns at the edge where the transfer happens
    task automatic send_test(input logic [31:0] cand, input logic [31:0] base);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {base, cand};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Result side: backpressure, scoreboard, watchdog
    // ---------------------------------------------------------------

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            m_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else if (!rx_idle_on) begin
            m_tready <= 1'b1;
        end else begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_tready <= 1'b1;
            end else if (r < 97) begin
                m_tready <= 1'b0;
                rx_stall_left = $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_stall_left = $urandom_range(20, 2000);
            end
        end
    end

    always @(posedge aclk) begin : scoreboard
        pending_verdict_t exp_v;
        bit moved;
        moved = 1'b0;
        if (aresetn && s_tvalid && s_tready) begin
            exp_v.cand    = s_tdata[31:0];
            exp_v.base    = s_tdata[63:32];
            exp_v.verdict = predict_verdict(exp_v.cand, exp_v.base);
            expected_verdicts.push_back(exp_v);
            moved = 1'b1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            moved = 1'b1;
            if (expected_verdicts.size() == 0) begin
                $display("%0t: verdict with no test pending: expected none, got 0x%02h",
                         $time, m_tdata);
                err_count++;
            end else begin
                exp_v = expected_verdicts.pop_front();
                if (m_tdata[0] !== exp_v.verdict.probable_prime) begin
                    $display("%0t: probable_prime n=%0d a=%0d: expected %0b, got %0b",
                             $time, exp_v.cand, exp_v.base,
                             exp_v.verdict.probable_prime, m_tdata[0]);
                    err_count++;
                end
                if (m_tdata[1] !== exp_v.verdict.invalid_candidate) begin
                    $display("%0t: invalid_candidate n=%0d a=%0d: expected %0b, got %0b",
                             $time, exp_v.cand, exp_v.base,
                             exp_v.verdict.invalid_candidate, m_tdata[1]);
                    err_count++;
                end
                if (m_tdata[7:2] !== 6'd0) begin
                    $display("%0t: tdata pad bits n=%0d a=%0d: expected 0x00, got 0x%02h",
                             $time, exp_v.cand, exp_v.base, m_tdata[7:2]);
                    err_count++;
                end
            end
        end
        quiet_cycles <= moved ? 0 : quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // n of 0 and 1 must be flagged without running the round
    task automatic test_invalid_candidates();
        send_test(32'd0, 32'd0);
        send_test(32'd0, 32'hFFFF_FFFF);
        send_test(32'd1, 32'd5);
        send_test(32'd1, 32'hFFFF_FFFF);
    endtask

    // Smallest and largest candidates, bases at zero, one, n-1 and n itself
    task automatic test_boundaries();
        send_test(32'd2, 32'd0);
        send_test(32'd2, 32'd1);
        send_test(32'd2, 32'd2);
        send_test(32'd3, 32'd2);
        send_test(32'hFFFF_FFFF, 32'd2);
        send_test(32'd4294967291, 32'hFFFF_FFFF);
        send_test(32'd4294967291, 32'd4294967291);
        send_test(32'd4294967291, 32'd1);
        send_test(32'd65537, 32'd65536);
        // even candidates: only a^(n-1) == 1 can pass
        send_test(32'hFFFF_FFFE, 32'd3);
        send_test(32'd4, 32'd3);
    endtask

    // Composites that pass, and a Carmichael number that does not
    task automatic test_strong_pseudoprimes();
        send_test(32'd2047, 32'd2);
        send_test(32'd3215031751, 32'd2);
        send_test(32'd561, 32'd2);
        send_test(32'd25326001, 32'd3);
    endtask

    // Primes with random bases: the full squaring chain gets exercised
    task automatic test_random_primes(input int count);
        logic [31:0] n;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            n = random_prime();
            send_test(n, random_base(n));
        end
    endtask

    task automatic test_random_odd(input int count);
        logic [31:0] n;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            n    = random_candidate();
            n[0] = 1'b1;
            send_test(n, random_base(n));
        end
    endtask

    // Anything goes: tiny, even and invalid candidates mixed in
    task automatic test_random_mixed(input int count);
        logic [31:0] n;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int i = 0; i < count; i++) begin
            if (i == count - 10) rx_idle_on = 1'b0;
            n = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 3)) : random_candidate();
            send_test(n, random_base(n));
        end
    endtask

    // Drop valid and let every verdict drain before the report
    task automatic finish_run();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_verdicts.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_invalid_candidates();
        test_boundaries();
        test_strong_pseudoprimes();
        test_random_primes(70);
        test_random_odd(60);
        test_random_mixed(60);
        finish_run();

        if (err_count == 0 && expected_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
